### rtl/tpri_pkg.sv
// Shared constants and types of the three-phase RMS imbalance checker.
package tpri_pkg;

  localparam int SAMPLE_W  = 16;   // phase sample width
  localparam int RMS_W     = 16;   // RMS and ratio field width
  localparam int Q14_FRAC  = 14;   // fraction bits of the Q2.14 ratios
  localparam int WIN_W     = 14;   // window_length register width
  localparam int TOL_W     = 16;   // tolerance register width
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 3 * SAMPLE_W;
  localparam int OUT_W     = 88;   // 5 x 16 bits + flag, padded to bytes

  localparam int DEF_MAX_WINDOW = 8192;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4096);
  localparam logic [TOL_W-1:0] TOL_RESET    = TOL_W'(9830);   // 0.15 in Q0.16
  localparam logic [RMS_W-1:0] SAT16        = '1;
  localparam logic [RMS_W+1:0] Q16_ONE      = (RMS_W+2)'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_TOLERANCE     = 2'd1
  } cfg_reg_e;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SQR   = 10'b00_0000_0010,
    S_LOAD  = 10'b00_0000_0100,
    S_DIV   = 10'b00_0000_1000,
    S_ROOT  = 10'b00_0001_0000,
    S_PUSH  = 10'b00_0010_0000,
    S_RLOAD = 10'b00_0100_0000,
    S_RATIO = 10'b00_1000_0000,
    S_RPUSH = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

endpackage

### rtl/three_phase_rms_imbalance_check_unit.sv
// Three-phase current RMS and imbalance checker, top level.
//
// Input stream s_axis: one transfer carries one sample of phases A, B and C.
// Each sample's square is summed per phase. On the window's last sample the
// block divides each sum by the window length, takes the floor square root,
// forms the B/A and C/A ratios in Q2.14 and flags a deviation from one above
// the tolerance. That result leaves on m_axis; other samples give no output.
// Config port: cfg_index_i 0 writes window_length, 1 writes tolerance, other
// indexes are ignored. cfg_ready_o is always high; write only while idle.
//
// A sample that does not close a window passes through the squaring steps
// before s_axis_tready_o returns (one 16x16 multiplier shared by the phases).
// A closing sample then runs division, root and ratio on one shared
// subtract/compare unit, with WORK_W division steps and SQRT_W root steps per
// phase and 30 steps a ratio.
// The result sits in an output register; a stalled receiver holds it and the
// block keeps taking samples until the next result is ready, which then
// waits until the register frees up.
// Reset: sums and sample count clear, registers return to 4096 and 0.15.
module three_phase_rms_imbalance_check_unit #(
  parameter int MAX_WINDOW = tpri_pkg::DEF_MAX_WINDOW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // phase_a [15:0], phase_b [31:16], phase_c [47:32]
  input  logic [tpri_pkg::IN_W-1:0]      s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // rms_a [15:0], rms_b [31:16], rms_c [47:32], ratio_b [63:48],
  // ratio_c [79:64], imbalance [80], zero pad [87:81]
  output logic [tpri_pkg::OUT_W-1:0]     m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tpri_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tpri_pkg::TOL_W-1:0]     cfg_data_i
);
  import tpri_pkg::*;

  localparam int SUM_W       = 2 * SAMPLE_W - 1 + $clog2(MAX_WINDOW);
  localparam int SQRT_W      = (SUM_W + 1) / 2;
  localparam int WORK_W      = 2 * SQRT_W;
  localparam int ALU_W       = SQRT_W + 3;
  localparam int STEP_W      = $clog2(WORK_W);
  localparam int SQR_STEPS   = 4;
  localparam int RATIO_STEPS = RMS_W + Q14_FRAC;
  localparam int PROD_W      = 2 * SAMPLE_W;

  state_e                state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [1:0]            ph_q, ph_d;
  logic [WORK_W-1:0]     work_q, work_d;
  logic [ALU_W-1:0]      rem_q, rem_d;
  logic [SQRT_W-1:0]     root_q, root_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [SAMPLE_W-1:0]   samp_q[3], samp_d[3];
  logic [SUM_W-1:0]      ring_q[3], ring_d[3];
  logic [RMS_W-1:0]      rms_q[3], rms_d[3];
  logic [RMS_W-1:0]      ratio_q[2], ratio_d[2];
  logic [WIN_W-1:0]      cnt_q, cnt_d;
  logic [WIN_W-1:0]      len_q, len_d;
  logic                  close_q, close_d;
  logic [OUT_W-1:0]      mdata_q, mdata_d;
  logic                  mvalid_q, mvalid_d;
  logic [WIN_W-1:0]      win_q;
  logic [TOL_W-1:0]      tol_q;

  logic [WIN_W-1:0]      eff_len;
  logic [WIN_W-1:0]      cnt_next;
  logic [SAMPLE_W-1:0]   mag;
  logic [ALU_W-1:0]      alu_a, alu_b, alu_res;
  logic [ALU_W:0]        alu_diff;
  logic                  alu_ge;
  logic                  imb;

  function automatic logic deviates(logic [RMS_W-1:0] ratio, logic [TOL_W-1:0] tol);
    logic [RMS_W+1:0] q16;
    logic [RMS_W+1:0] dev;
    q16 = {ratio, 2'b00};
    dev = (q16 >= Q16_ONE) ? (q16 - Q16_ONE) : (Q16_ONE - q16);
    return dev > {2'b00, tol};
  endfunction

  // window length as used: zero reads as one, clamped to MAX_WINDOW
  always_comb begin
    if (win_q == '0) begin
      eff_len = WIN_W'(1);
    end else if (32'(win_q) > MAX_WINDOW) begin
      eff_len = WIN_W'(MAX_WINDOW);
    end else begin
      eff_len = win_q;
    end
  end

  assign cnt_next = cnt_q + 1'b1;
  assign mag      = samp_q[0][SAMPLE_W-1] ? (~samp_q[0] + 1'b1) : samp_q[0];

  // shared restoring subtract/compare step: division, root and ratio
  always_comb begin
    if (state_q == S_ROOT) begin
      alu_a = {rem_q[ALU_W-3:0], work_q[WORK_W-1 -: 2]};
      alu_b = ALU_W'({root_q, 2'b01});
    end else if (state_q == S_DIV) begin
      alu_a = {rem_q[ALU_W-2:0], work_q[WORK_W-1]};
      alu_b = ALU_W'(len_q);
    end else begin
      alu_a = {rem_q[ALU_W-2:0], work_q[WORK_W-1]};
      alu_b = ALU_W'(rms_q[0]);
    end
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge   = ~alu_diff[ALU_W];
    alu_res  = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;
  end

  // rms_a of zero: ratios already saturate (all quotient bits set), flag held low
  assign imb = (rms_q[0] != '0) &&
               (deviates(ratio_q[0], tol_q) || deviates(ratio_q[1], tol_q));

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    ph_d     = ph_q;
    work_d   = work_q;
    rem_d    = rem_q;
    root_d   = root_q;
    prod_d   = prod_q;
    samp_d   = samp_q;
    ring_d   = ring_q;
    rms_d    = rms_q;
    ratio_d  = ratio_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    close_d  = close_q;
    mdata_d  = mdata_q;
    mvalid_d = mvalid_q;

    if (mvalid_q && m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          samp_d[0] = s_axis_tdata_i[SAMPLE_W-1:0];
          samp_d[1] = s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W];
          samp_d[2] = s_axis_tdata_i[3*SAMPLE_W-1:2*SAMPLE_W];
          close_d   = (cnt_next == '0) || (cnt_next >= eff_len);
          cnt_d     = close_d ? '0 : cnt_next;
          len_d     = eff_len;
          step_d    = '0;
          state_d   = S_SQR;
        end
      end
      S_SQR: begin
        prod_d    = PROD_W'(mag) * PROD_W'(mag);
        samp_d[0] = samp_q[1];
        samp_d[1] = samp_q[2];
        if (step_q != '0) begin
          // sums rotate so the add always lands on one fixed tap
          ring_d[0] = ring_q[1];
          ring_d[1] = ring_q[2];
          ring_d[2] = ring_q[0] + SUM_W'(prod_q);
        end
        if (step_q == STEP_W'(SQR_STEPS - 1)) begin
          ph_d    = '0;
          state_d = close_q ? S_LOAD : S_IDLE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_LOAD: begin
        work_d    = WORK_W'(ring_q[0]);
        ring_d[0] = ring_q[1];
        ring_d[1] = ring_q[2];
        ring_d[2] = '0;
        rem_d     = '0;
        step_d    = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        rem_d  = alu_res;
        work_d = {work_q[WORK_W-2:0], alu_ge};
        if (step_q == STEP_W'(WORK_W - 1)) begin
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = S_ROOT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_ROOT: begin
        rem_d  = alu_res;
        root_d = {root_q[SQRT_W-2:0], alu_ge};
        work_d = {work_q[WORK_W-3:0], 2'b00};
        if (step_q == STEP_W'(SQRT_W - 1)) begin
          state_d = S_PUSH;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_PUSH: begin
        rms_d[0] = rms_q[1];
        rms_d[1] = rms_q[2];
        rms_d[2] = (root_q > SQRT_W'(SAT16)) ? SAT16 : root_q[RMS_W-1:0];
        if (ph_q == 2'd2) begin
          ph_d    = '0;
          state_d = S_RLOAD;
        end else begin
          ph_d    = ph_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_RLOAD: begin
        work_d  = {(ph_q == '0) ? rms_q[1] : rms_q[2], (WORK_W-RMS_W)'(0)};
        rem_d   = '0;
        step_d  = '0;
        state_d = S_RATIO;
      end
      S_RATIO: begin
        rem_d  = alu_res;
        work_d = {work_q[WORK_W-2:0], alu_ge};
        if (step_q == STEP_W'(RATIO_STEPS - 1)) begin
          state_d = S_RPUSH;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_RPUSH: begin
        ratio_d[0] = ratio_q[1];
        ratio_d[1] = (work_q[RATIO_STEPS-1:RMS_W] != '0) ? SAT16 : work_q[RMS_W-1:0];
        if (ph_q == '0) begin
          ph_d    = 2'd1;
          state_d = S_RLOAD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mdata_d  = {(OUT_W-5*RMS_W-1)'(0), imb, ratio_q[1], ratio_q[0],
                      rms_q[2], rms_q[1], rms_q[0]};
          mvalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      ph_q     <= '0;
      cnt_q    <= '0;
      close_q  <= 1'b0;
      mvalid_q <= 1'b0;
      ring_q   <= '{default: '0};
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      ph_q     <= ph_d;
      cnt_q    <= cnt_d;
      close_q  <= close_d;
      mvalid_q <= mvalid_d;
      ring_q   <= ring_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    prod_q  <= prod_d;
    samp_q  <= samp_d;
    rms_q   <= rms_d;
    ratio_q <= ratio_d;
    len_q   <= len_d;
    mdata_q <= mdata_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_RESET;
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WINDOW_LENGTH: win_q <= cfg_data_i[WIN_W-1:0];
        REG_TOLERANCE:     tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;

  // all three sums are cleared once the per-phase roots are done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RLOAD) |-> (ring_q[0] == '0 && ring_q[1] == '0 && ring_q[2] == '0))
    else $error("sums not cleared after window close");

  // zero phase A RMS: both ratios saturate and no imbalance is flagged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[RMS_W-1:0] == '0) |->
      (m_axis_tdata_o[4*RMS_W-1:3*RMS_W] == SAT16 &&
       m_axis_tdata_o[5*RMS_W-1:4*RMS_W] == SAT16 &&
       !m_axis_tdata_o[5*RMS_W]))
    else $error("zero phase A result not saturated");

  // a finished result is loaded whenever the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!mvalid_q || m_axis_tready_i)) |=>
      (m_axis_tvalid_o && state_q == S_IDLE))
    else $error("result not loaded into output register");

endmodule
